### hw/rtl/pbc_pkg.sv
// pbc_pkg: shared types and constants for the polygon bounding box and convexity unit
// holds the turn classification codes and the fixed tolerance width
// no dependencies
package pbc_pkg;

	// width of the collinear tolerance register
	localparam int TOL_W = 16;

	// cross products classified per transfer: middle vertex and two wrap-around vertices
	localparam int NUM_SLOTS = 3;

	// classification of one cross product
	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_COLLINEAR,
		CLS_POSITIVE,
		CLS_NEGATIVE
	} cls_t;

endpackage

### hw/rtl/polygon_bbox_convexity_unit.sv
// polygon_bbox_convexity_unit: streaming bounding box and convexity test over polygon vertices
// six-register pipeline from vertex transfer to result register
// depends on pbc_pkg
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------------------
//   vertex   | in_valid / in_stall   | vertex_x, vertex_y, last_vertex
//   result   | out_valid / out_stall | min_x, min_y, max_x, max_y, collinear_count,
//            |                       | turn_sum, vertex_total, convex
//   config   | cfg_wr_en             | cfg_wr_data (collinear tolerance)
//
// one vertex per cycle while in_stall is low; out_valid rises once the last vertex reaches the result register
// the stages are: differences, products, cross product, classification, tallies, result
// arst_n clears the pipeline valids, the vertex count, the tallies and the tolerance
// a stalled result holds the result register and the finished counts behind it; earlier
// stages keep taking vertices until a third finished result waits in the classification stage
module polygon_bbox_convexity_unit
	import pbc_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int COORD_BITS   = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_wr_en,
	input  logic [TOL_W-1:0]                          cfg_wr_data,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic signed [COORD_BITS-1:0]              vertex_x,
	input  logic signed [COORD_BITS-1:0]              vertex_y,
	input  logic                                      last_vertex,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [COORD_BITS-1:0]              min_x,
	output logic signed [COORD_BITS-1:0]              min_y,
	output logic signed [COORD_BITS-1:0]              max_x,
	output logic signed [COORD_BITS-1:0]              max_y,
	output logic [$clog2(MAX_VERTICES+1)-1:0]         collinear_count,
	output logic signed [$clog2(MAX_VERTICES+1):0]    turn_sum,
	output logic [$clog2(MAX_VERTICES+1)-1:0]         vertex_total,
	output logic                                      convex
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W = $clog2(MAX_VERTICES + 2);
	localparam int DW    = COORD_BITS + 1;
	localparam int PRW   = 2 * DW;
	localparam int PW    = PRW + 1;
	localparam int CMP_W = (PW > TOL_W + 1) ? PW : TOL_W + 1;

	localparam logic [IDX_W-1:0]        IDX_MAX    = IDX_W'(MAX_VERTICES + 1);
	localparam logic [IDX_W-1:0]        IDX_CAP    = IDX_W'(MAX_VERTICES);
	localparam logic [CNT_W-1:0]        CNT_MAX    = CNT_W'(MAX_VERTICES);
	localparam logic signed [CNT_W:0]   TURN_MAX   = (CNT_W+1)'(MAX_VERTICES);
	localparam logic signed [CNT_W:0]   TURN_MIN   = (CNT_W+1)'(-MAX_VERTICES);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} pt_t;

	typedef struct packed {
		logic              last;
		pt_t               lo;
		pt_t               hi;
		logic [CNT_W-1:0]  total;
	} meta_t;

	function automatic logic signed [DW-1:0] coord_sub(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		return DW'(a) - DW'(b);
	endfunction

	// tolerance register
	logic [TOL_W-1:0]         tol_q;
	logic signed [CMP_W-1:0]  neg_tol_q;
	logic signed [CMP_W-1:0]  tol_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q     <= '0;
			neg_tol_q <= '0;
		end else if (cfg_wr_en) begin
			tol_q     <= cfg_wr_data;
			neg_tol_q <= -signed'(CMP_W'(cfg_wr_data));
		end
	end

	assign tol_ext = signed'(CMP_W'(tol_q));

	// pipeline control
	logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, out_valid_q;
	logic s1_en, s2_en, s3_en, s4_en, s5_en, out_en;
	logic in_fire;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4;

	always_comb begin
		out_en = !out_valid_q || !out_stall;
		s5_en  = !s5_valid || out_en;
		s4_en  = !s4_valid || !meta_s4.last || s5_en;
		s3_en  = !s3_valid || s4_en;
		s2_en  = !s2_valid || s3_en;
		s1_en  = !s1_valid || s2_en;
	end

	assign in_stall = !s1_en;
	assign in_fire  = in_valid && s1_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			s3_valid    <= 1'b0;
			s4_valid    <= 1'b0;
			s5_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_en) s1_valid <= in_valid;
			if (s2_en) s2_valid <= s1_valid;
			if (s3_en) s3_valid <= s2_valid;
			if (s4_en) s4_valid <= s3_valid;
			if (s5_en) s5_valid <= s4_valid && meta_s4.last;
			if (out_en) out_valid_q <= s5_valid;
		end
	end

	// vertex history and running box
	logic [IDX_W-1:0] idx_q;
	pt_t first_q, second_q, older_q, newer_q, box_lo_q, box_hi_q;
	pt_t v, second_eff, box_lo_nx, box_hi_nx;
	logic is0, is1;
	logic [CNT_W-1:0] total_nx;
	pt_t prev_pt [NUM_SLOTS];
	pt_t cur_pt  [NUM_SLOTS];
	pt_t next_pt [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] slot_en;

	always_comb begin
		v.x        = vertex_x;
		v.y        = vertex_y;
		is0        = (idx_q == '0);
		is1        = (idx_q == IDX_W'(1));
		second_eff = is1 ? v : second_q;

		// box update, seeded by the first vertex
		box_lo_nx = box_lo_q;
		box_hi_nx = box_hi_q;
		if (is0) begin
			box_lo_nx = v;
			box_hi_nx = v;
		end else begin
			if (v.x < box_lo_q.x) box_lo_nx.x = v.x;
			if (v.y < box_lo_q.y) box_lo_nx.y = v.y;
			if (v.x > box_hi_q.x) box_hi_nx.x = v.x;
			if (v.y > box_hi_q.y) box_hi_nx.y = v.y;
		end

		total_nx = (idx_q >= IDX_CAP) ? CNT_MAX : CNT_W'(idx_q) + CNT_W'(1);

		// middle vertex: the one before this one
		slot_en[0] = !is0 && !is1;
		prev_pt[0] = older_q;
		cur_pt[0]  = newer_q;
		next_pt[0] = v;

		// wrap-around at the last vertex itself
		slot_en[1] = last_vertex;
		prev_pt[1] = is0 ? v : newer_q;
		cur_pt[1]  = v;
		next_pt[1] = is0 ? v : first_q;

		// wrap-around at the first vertex
		slot_en[2] = last_vertex && !is0;
		prev_pt[2] = v;
		cur_pt[2]  = first_q;
		next_pt[2] = second_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (in_fire) begin
			if (last_vertex) idx_q <= '0;
			else if (idx_q < IDX_MAX) idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (is0) first_q <= v;
			if (is1) second_q <= v;
			older_q  <= newer_q;
			newer_q  <= v;
			box_lo_q <= box_lo_nx;
			box_hi_q <= box_hi_nx;
		end
	end

	// stage 1: edge vectors
	logic signed [DW-1:0] ax_s1 [NUM_SLOTS];
	logic signed [DW-1:0] ay_s1 [NUM_SLOTS];
	logic signed [DW-1:0] bx_s1 [NUM_SLOTS];
	logic signed [DW-1:0] by_s1 [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] en_s1, en_s2, en_s3;

	always_ff @(posedge clk) begin
		if (s1_en) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				ax_s1[i] <= coord_sub(prev_pt[i].x, cur_pt[i].x);
				ay_s1[i] <= coord_sub(prev_pt[i].y, cur_pt[i].y);
				bx_s1[i] <= coord_sub(next_pt[i].x, cur_pt[i].x);
				by_s1[i] <= coord_sub(next_pt[i].y, cur_pt[i].y);
			end
			en_s1         <= slot_en;
			meta_s1.last  <= last_vertex;
			meta_s1.lo    <= box_lo_nx;
			meta_s1.hi    <= box_hi_nx;
			meta_s1.total <= total_nx;
		end
	end

	// stage 2: partial products of the cross products
	logic signed [PRW-1:0] p_s2 [NUM_SLOTS];
	logic signed [PRW-1:0] q_s2 [NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (s2_en) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				p_s2[i] <= PRW'(ax_s1[i]) * PRW'(by_s1[i]);
				q_s2[i] <= PRW'(ay_s1[i]) * PRW'(bx_s1[i]);
			end
			en_s2   <= en_s1;
			meta_s2 <= meta_s1;
		end
	end

	// stage 3: z cross product
	logic signed [PW-1:0] z_s3 [NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (s3_en) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				z_s3[i] <= PW'(p_s2[i]) - PW'(q_s2[i]);
			end
			en_s3   <= en_s2;
			meta_s3 <= meta_s2;
		end
	end

	// stage 4: classify against the tolerance window
	cls_t cls_nx [NUM_SLOTS];
	cls_t cls_s4 [NUM_SLOTS];
	logic signed [CMP_W-1:0] z_ext [NUM_SLOTS];

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			z_ext[i] = CMP_W'(z_s3[i]);
			if (!en_s3[i]) cls_nx[i] = CLS_NONE;
			else if (z_ext[i] <= tol_ext && z_ext[i] >= neg_tol_q) cls_nx[i] = CLS_COLLINEAR;
			else if (!z_s3[i][PW-1]) cls_nx[i] = CLS_POSITIVE;
			else cls_nx[i] = CLS_NEGATIVE;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_en) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				cls_s4[i] <= cls_nx[i];
			end
			meta_s4 <= meta_s3;
		end
	end

	// tallies, updated in slot order with saturation
	logic [CNT_W-1:0]       col_tally_q, col_nx;
	logic signed [CNT_W:0]  turn_tally_q, turn_nx;
	logic                   tally_fire;

	always_comb begin
		col_nx  = col_tally_q;
		turn_nx = turn_tally_q;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			unique case (cls_s4[i])
				CLS_COLLINEAR: if (col_nx < CNT_MAX) col_nx = col_nx + CNT_W'(1);
				CLS_POSITIVE:  if (turn_nx < TURN_MAX) turn_nx = turn_nx + (CNT_W+1)'(1);
				CLS_NEGATIVE:  if (turn_nx > TURN_MIN) turn_nx = turn_nx - (CNT_W+1)'(1);
				default:       ;
			endcase
		end
	end

	assign tally_fire = s4_valid && s4_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_tally_q  <= '0;
			turn_tally_q <= '0;
		end else if (tally_fire) begin
			if (meta_s4.last) begin
				col_tally_q  <= '0;
				turn_tally_q <= '0;
			end else begin
				col_tally_q  <= col_nx;
				turn_tally_q <= turn_nx;
			end
		end
	end

	// stage 5: finished polygon counts
	logic [CNT_W-1:0]       col_s5;
	logic signed [CNT_W:0]  turn_s5;
	meta_t                  meta_s5;

	always_ff @(posedge clk) begin
		if (s5_en) begin
			col_s5  <= col_nx;
			turn_s5 <= turn_nx;
			meta_s5 <= meta_s4;
		end
	end

	// result register with the convexity check
	pt_t                    out_lo_q, out_hi_q;
	logic [CNT_W-1:0]       out_col_q, out_total_q;
	logic signed [CNT_W:0]  out_turn_q;
	logic                   out_convex_q;
	logic signed [CNT_W+1:0] count_sum;
	logic signed [CNT_W+1:0] total_ext;

	assign count_sum = signed'((CNT_W+2)'(col_s5)) + (CNT_W+2)'(turn_s5);
	assign total_ext = signed'((CNT_W+2)'(meta_s5.total));

	always_ff @(posedge clk) begin
		if (out_en) begin
			out_lo_q     <= meta_s5.lo;
			out_hi_q     <= meta_s5.hi;
			out_col_q    <= col_s5;
			out_turn_q   <= turn_s5;
			out_total_q  <= meta_s5.total;
			out_convex_q <= (count_sum == total_ext);
		end
	end

	assign out_valid       = out_valid_q;
	assign min_x           = out_lo_q.x;
	assign min_y           = out_lo_q.y;
	assign max_x           = out_hi_q.x;
	assign max_y           = out_hi_q.y;
	assign collinear_count = out_col_q;
	assign turn_sum        = out_turn_q;
	assign vertex_total    = out_total_q;
	assign convex          = out_convex_q;

endmodule

### bench/polygon_bbox_convexity_checker.sv
// polygon_bbox_convexity_checker: watches the vertex, result and tolerance ports of the unit
// folds every accepted vertex into its own polygon state and compares each result transfer
// depends on pbc_pkg
module polygon_bbox_convexity_checker
	import pbc_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int COORD_BITS   = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [TOL_W-1:0]                       cfg_wr_data,
	input  logic                                   in_valid,
	input  logic                                   in_stall,
	input  logic signed [COORD_BITS-1:0]           vertex_x,
	input  logic signed [COORD_BITS-1:0]           vertex_y,
	input  logic                                   last_vertex,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic signed [COORD_BITS-1:0]           min_x,
	input  logic signed [COORD_BITS-1:0]           min_y,
	input  logic signed [COORD_BITS-1:0]           max_x,
	input  logic signed [COORD_BITS-1:0]           max_y,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]      collinear_count,
	input  logic signed [$clog2(MAX_VERTICES+1):0] turn_sum,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]      vertex_total,
	input  logic                                   convex,
	output int                                     fail_count,
	output int                                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	// one finished polygon as the unit reports it
	typedef struct {
		logic signed [COORD_BITS-1:0] min_x;
		logic signed [COORD_BITS-1:0] min_y;
		logic signed [COORD_BITS-1:0] max_x;
		logic signed [COORD_BITS-1:0] max_y;
		logic [CNT_W-1:0]             collinear_count;
		logic signed [CNT_W:0]        turn_sum;
		logic [CNT_W-1:0]             vertex_total;
		logic                         convex;
	} poly_summary_t;

	poly_summary_t expected_summaries[$];

	// running polygon state
	logic [TOL_W-1:0] tolerance;
	longint first_x, first_y, second_x, second_y;
	longint older_x, older_y, newer_x, newer_y;
	longint low_x, low_y, high_x, high_y;
	int collinear_tally, turn_tally, vertex_index;
	int mismatches;

	task automatic clear_polygon();
		first_x = 0; first_y = 0; second_x = 0; second_y = 0;
		older_x = 0; older_y = 0; newer_x = 0; newer_y = 0;
		low_x = 0; low_y = 0; high_x = 0; high_y = 0;
		collinear_tally = 0;
		turn_tally = 0;
		vertex_index = 0;
	endtask

	// z cross product of (prev - cur) x (next - cur), exact in 64 bits
	function automatic cls_t classify_corner(input longint px, input longint py,
			input longint cx, input longint cy, input longint nx, input longint ny);
		longint p, q, mag;
		p = (px - cx) * (ny - cy);
		q = (py - cy) * (nx - cx);
		mag = (p >= q) ? p - q : q - p;
		if (mag <= longint'(tolerance))
			return CLS_COLLINEAR;
		return (p >= q) ? CLS_POSITIVE : CLS_NEGATIVE;
	endfunction

	// saturating tallies
	task automatic count_corner(input cls_t cls);
		case (cls)
			CLS_COLLINEAR: begin
				if (collinear_tally < MAX_VERTICES)
					collinear_tally++;
			end
			CLS_POSITIVE: begin
				if (turn_tally < MAX_VERTICES)
					turn_tally++;
			end
			CLS_NEGATIVE: begin
				if (turn_tally > -MAX_VERTICES)
					turn_tally--;
			end
			default: ;
		endcase
	endtask

	// fold one accepted vertex, queue a summary on the last one
	task automatic fold_vertex(input longint vx, input longint vy, input logic is_last);
		int k, total;
		poly_summary_t s;
		k = vertex_index;
		if (k == 0) begin
			first_x = vx; first_y = vy;
			low_x = vx; low_y = vy;
			high_x = vx; high_y = vy;
		end else begin
			if (vx < low_x) low_x = vx;
			if (vy < low_y) low_y = vy;
			if (vx > high_x) high_x = vx;
			if (vy > high_y) high_y = vy;
			if (k == 1) begin
				second_x = vx; second_y = vy;
			end else
				count_corner(classify_corner(older_x, older_y, newer_x, newer_y, vx, vy));
		end

		if (!is_last) begin
			older_x = newer_x; older_y = newer_y;
			newer_x = vx; newer_y = vy;
			if (vertex_index < MAX_VERTICES + 1)
				vertex_index++;
		end else begin
			// wrap-around corners: the last vertex and the first one
			if (k == 0)
				count_corner(classify_corner(vx, vy, vx, vy, vx, vy));
			else begin
				count_corner(classify_corner(newer_x, newer_y, vx, vy, first_x, first_y));
				count_corner(classify_corner(vx, vy, first_x, first_y, second_x, second_y));
			end
			total = (k + 1 > MAX_VERTICES) ? MAX_VERTICES : k + 1;
			s.min_x = low_x[COORD_BITS-1:0];
			s.min_y = low_y[COORD_BITS-1:0];
			s.max_x = high_x[COORD_BITS-1:0];
			s.max_y = high_y[COORD_BITS-1:0];
			s.collinear_count = collinear_tally[CNT_W-1:0];
			s.turn_sum = turn_tally[CNT_W:0];
			s.vertex_total = total[CNT_W-1:0];
			s.convex = (total == collinear_tally + turn_tally);
			expected_summaries.push_back(s);
			clear_polygon();
		end
	endtask

	task automatic check_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	// compare a result transfer against the oldest summary
	task automatic check_summary();
		poly_summary_t s;
		if (expected_summaries.size() == 0) begin
			$display("%0t ns: result transfer with none expected, actual box (%0d,%0d)-(%0d,%0d)",
				$time, min_x, min_y, max_x, max_y);
			mismatches++;
		end else begin
			s = expected_summaries.pop_front();
			check_field("min_x", s.min_x, min_x);
			check_field("min_y", s.min_y, min_y);
			check_field("max_x", s.max_x, max_x);
			check_field("max_y", s.max_y, max_y);
			check_field("collinear_count", s.collinear_count, collinear_count);
			check_field("turn_sum", s.turn_sum, turn_sum);
			check_field("vertex_total", s.vertex_total, vertex_total);
			check_field("convex", s.convex, convex);
		end
	endtask

	// sample all channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance = '0;
			clear_polygon();
			expected_summaries.delete();
			mismatches = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_wr_en)
				tolerance = cfg_wr_data;
			if (in_valid && !in_stall)
				fold_vertex(vertex_x, vertex_y, last_vertex);
			if (out_valid && !out_stall)
				check_summary();
			pending <= expected_summaries.size();
			fail_count <= mismatches;
		end
	end

endmodule

### bench/polygon_bbox_convexity_unit_tb.sv
// polygon_bbox_convexity_unit_tb: clock, reset, vertex stimulus and result stalls for the unit
// directed polygons, random polygons under several tolerances and idling mixes
// depends on pbc_pkg, polygon_bbox_convexity_unit and polygon_bbox_convexity_checker
module polygon_bbox_convexity_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pbc_pkg::*;

	localparam int MAX_VERTICES = 1024;
	localparam int COORD_BITS   = 16;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_VERTS  = 155;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [TOL_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_BITS-1:0] vertex_x = '0;
	logic signed [COORD_BITS-1:0] vertex_y = '0;
	logic last_vertex = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [COORD_BITS-1:0] min_x, min_y, max_x, max_y;
	logic [CNT_W-1:0] collinear_count, vertex_total;
	logic signed [CNT_W:0] turn_sum;
	logic convex;

	int fail_count, pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_trigger = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int poly_x[$], poly_y[$];

	polygon_bbox_convexity_unit #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.vertex_x       (vertex_x),
		.vertex_y       (vertex_y),
		.last_vertex    (last_vertex),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.min_x          (min_x),
		.min_y          (min_y),
		.max_x          (max_x),
		.max_y          (max_y),
		.collinear_count(collinear_count),
		.turn_sum       (turn_sum),
		.vertex_total   (vertex_total),
		.convex         (convex)
	);

	polygon_bbox_convexity_checker #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.vertex_x       (vertex_x),
		.vertex_y       (vertex_y),
		.last_vertex    (last_vertex),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.min_x          (min_x),
		.min_y          (min_y),
		.max_x          (max_x),
		.max_y          (max_y),
		.collinear_count(collinear_count),
		.turn_sum       (turn_sum),
		.vertex_total   (vertex_total),
		.convex         (convex),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// one vertex transfer, with random idle cycles in front
	task automatic send_vertex(input int x, input int y, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		vertex_x <= x[COORD_BITS-1:0];
		vertex_y <= y[COORD_BITS-1:0];
		last_vertex <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_polygon();
		for (int i = 0; i < poly_x.size(); i++)
			send_vertex(poly_x[i], poly_y[i], i == poly_x.size() - 1);
	endtask

	task automatic add_vertex(input int x, input int y);
		poly_x.push_back(x);
		poly_y.push_back(y);
	endtask

	// points on a circle, counter-clockwise or clockwise
	task automatic add_arc(input int n, input int cx, input int cy, input int r, input bit ccw);
		real angle;
		for (int i = 0; i < n; i++) begin
			angle = 6.283185307179586 * i / n;
			if (!ccw)
				angle = -angle;
			add_vertex(cx + $rtoi(r * $cos(angle)), cy + $rtoi(r * $sin(angle)));
		end
	endtask

	function automatic int any_coord();
		return int'($urandom_range(65535)) - 32768;
	endfunction

	function automatic int corner_coord();
		case ($urandom_range(3))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return any_coord();
		endcase
	endfunction

	// well-formed shapes, clusters, lines, noise and corner coordinates
	task automatic make_random_polygon();
		int kind, n, cx, cy, r, dx, dy, span;
		poly_x.delete();
		poly_y.delete();
		kind = $urandom_range(9);
		case (kind)
			0, 1, 2, 3: begin
				n = $urandom_range(3, 12);
				r = $urandom_range(4, 20000);
				span = 32767 - r;
				cx = int'($urandom_range(2 * span)) - span;
				cy = int'($urandom_range(2 * span)) - span;
				add_arc(n, cx, cy, r, kind != 3);
			end
			4, 5: begin
				n = $urandom_range(1, 10);
				cx = int'($urandom_range(64000)) - 32000;
				cy = int'($urandom_range(64000)) - 32000;
				for (int i = 0; i < n; i++)
					add_vertex(cx + int'($urandom_range(16)) - 8, cy + int'($urandom_range(16)) - 8);
			end
			6, 7: begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++)
					add_vertex(any_coord(), any_coord());
			end
			8: begin
				n = $urandom_range(1, 8);
				cx = int'($urandom_range(2000)) - 1000;
				cy = int'($urandom_range(2000)) - 1000;
				dx = int'($urandom_range(100)) - 50;
				dy = int'($urandom_range(100)) - 50;
				for (int i = 0; i < n; i++)
					add_vertex(cx + i * dx + int'($urandom_range(2)) - 1,
						cy + i * dy + int'($urandom_range(2)) - 1);
			end
			default: begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					add_vertex(corner_coord(), corner_coord());
			end
		endcase
	endtask

	task automatic run_random(input int vertex_budget);
		int sent;
		sent = 0;
		while (sent < vertex_budget) begin
			make_random_polygon();
			sent += poly_x.size();
			send_polygon();
		end
	endtask

	// wait for every expected result, then for the pipeline to empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_tolerance(input logic [TOL_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_shape(input int xs[$], input int ys[$]);
		poly_x = xs;
		poly_y = ys;
		send_polygon();
	endtask

	// main stimulus
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed shapes at zero tolerance
		set_tolerance('0);
		send_shape('{-32768}, '{32767});
		send_shape('{32767, -32768}, '{-32768, 32767});
		send_shape('{0, 10, 0}, '{0, 0, 10});
		send_shape('{0, 0, 10}, '{0, 10, 0});
		send_shape('{-32768, 32767, 32767, -32768}, '{-32768, -32768, 32767, 32767});
		send_shape('{0, 1, 2, 3}, '{0, 1, 2, 3});
		send_shape('{0, 10, 2, 0}, '{0, 0, 2, 10});
		drain();

		// sender mostly busy, receiver mostly stalled, one long hold-off
		set_tolerance(16'hFFFF);
		send_idle_pct <= 10;
		recv_stall_pct <= 70;
		hold_trigger <= hold_trigger + 1;
		run_random(PHASE_VERTS);
		drain();

		// sender mostly idle, receiver mostly ready
		set_tolerance(TOL_W'($urandom_range(1, 200)));
		send_idle_pct <= 70;
		recv_stall_pct <= 10;
		run_random(PHASE_VERTS);
		drain();

		// no idling, another hold-off to fill the pipeline
		set_tolerance(TOL_W'($urandom_range(201, 65534)));
		send_idle_pct <= 0;
		recv_stall_pct <= 0;
		hold_trigger <= hold_trigger + 1;
		run_random(PHASE_VERTS);
		drain();

		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### polygon_bbox_convexity_unit.f
hw/rtl/pbc_pkg.sv
hw/rtl/polygon_bbox_convexity_unit.sv
bench/polygon_bbox_convexity_checker.sv
bench/polygon_bbox_convexity_unit_tb.sv
